FILE: rtl/ryuv_pkg.sv
// ----------------------------------------------------------------------------
// ryuv_pkg
// Shared types, constants and helpers of the RGB to planar YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package ryuv_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int COMP_W    = 8;
	localparam int SAMPLE_W  = 8;
	localparam int ADDR_W    = 25;
	localparam int SRC_W     = 24;
	localparam int LUMA_W    = 24;
	localparam int CHROMA_W  = 22;
	localparam int IMG_W     = 2 * CFG_W;
	localparam int COEF_W    = 12;
	localparam int SUM_W     = SAMPLE_W + 2;

	localparam int DEF_MAX_WIDTH   = 4096;
	localparam int DEF_MAX_HEIGHT  = 4096;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [CFG_W-1:0] DEF_FRAME_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] DEF_FRAME_HEIGHT = 13'd480;

	localparam logic [COEF_W-1:0] K_Y_R = 12'd1224;
	localparam logic [COEF_W-1:0] K_Y_G = 12'd2404;
	localparam logic [COEF_W-1:0] K_Y_B = 12'd469;
	localparam logic [COEF_W-1:0] K_U_R = 12'd692;
	localparam logic [COEF_W-1:0] K_U_G = 12'd1356;
	localparam logic [COEF_W-1:0] K_V_G = 12'd1731;
	localparam logic [COEF_W-1:0] K_V_B = 12'd334;
	localparam logic [SUM_W-1:0]  CHROMA_OFFSET = 10'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PLANE_Y = 2'd0,
		PLANE_U = 2'd1,
		PLANE_V = 2'd2
	} plane_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] y;
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] v;
		logic [LUMA_W-1:0]   luma_addr;
		logic [ADDR_W-1:0]   u_addr;
		logic [ADDR_W-1:0]   v_addr;
		logic [SRC_W-1:0]    src;
		logic                chroma;
		logic                fend;
	} ryuv_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ryuv_qstat_t;

	function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
	                                              input logic [CFG_W:0] maxv);
		logic [CFG_W:0] c;
		c = {1'b0, v};
		if (c < (CFG_W+1)'(2))
			c = (CFG_W+1)'(2);
		if (c > maxv)
			c = maxv;
		c[0] = 1'b0;
		return c[CFG_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] mul_shr(input logic [COMP_W-1:0] x,
	                                                input logic [COEF_W-1:0] k);
		logic [COMP_W+COEF_W-1:0] p;
		p = {{COEF_W{1'b0}}, x} * {{COMP_W{1'b0}}, k};
		return p[COMP_W+COEF_W-1:COEF_W];
	endfunction

endpackage

FILE: rtl/ryuv_fifo.sv
// ----------------------------------------------------------------------------
// ryuv_fifo
// Short word queue between the pixel front end and the result sequencer.
// ----------------------------------------------------------------------------
module ryuv_fifo import ryuv_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ryuv_item_t  push_item,
	input  logic        pop,
	output ryuv_item_t  head,
	output ryuv_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ryuv_item_t        entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("pop from empty queue");

endmodule

FILE: rtl/ryuv_front.sv
// ----------------------------------------------------------------------------
// ryuv_front
// Frame size registers, raster counters, color products and result addresses.
// ----------------------------------------------------------------------------
module ryuv_front import ryuv_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COMP_W-1:0]    red,
	input  logic [COMP_W-1:0]    green,
	input  logic [COMP_W-1:0]    blue,
	output logic                 push,
	output ryuv_item_t           push_item,
	input  ryuv_qstat_t          qstat
);

	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [CFG_W:0] MAXW = (CFG_W+1)'(MAX_WIDTH);
	localparam logic [CFG_W:0] MAXH = (CFG_W+1)'(MAX_HEIGHT);

	logic [CFG_W-1:0]    frame_width_q, frame_height_q;
	logic [CFG_W-1:0]    w_eff, h_eff;
	logic [IMG_W-1:0]    img_q;
	logic [COL_W-1:0]    column_q;
	logic [ROW_W-1:0]    row_q;
	logic [LUMA_W-1:0]   luma_q;
	logic [CHROMA_W-1:0] chroma_idx_q;
	logic                col_last, row_last, fend, chroma, accept, restart;
	logic                adv2, ld1;

	logic                s1_v_q;
	logic [COMP_W-1:0]   red_s1, green_s1, blue_s1;
	logic [COL_W-1:0]    column_s1;
	logic [LUMA_W-1:0]   luma_s1;
	logic [CHROMA_W-1:0] chroma_idx_s1;
	logic                chroma_s1, fend_s1;

	logic                s2_v_q;
	logic [COMP_W-1:0]   red_s2, blue_s2;
	logic [SAMPLE_W-1:0] t_yr_s2, t_yg_s2, t_yb_s2, t_ur_s2, t_ug_s2, t_vg_s2, t_vb_s2;
	logic [LUMA_W-1:0]   luma_s2;
	logic [ADDR_W-1:0]   u_addr_s2, v_addr_s2;
	logic [SRC_W-1:0]    src_s2;
	logic                chroma_s2, fend_s2;
	logic [SUM_W-1:0]    y_sum, u_sum, v_sum;

	assign w_eff    = eff_size(frame_width_q, MAXW);
	assign h_eff    = eff_size(frame_height_q, MAXH);
	assign col_last = (CFG_W'(column_q) == w_eff - CFG_W'(1));
	assign row_last = (CFG_W'(row_q) == h_eff - CFG_W'(1));
	assign fend     = col_last && row_last;
	assign chroma   = column_q[0] & row_q[0];
	assign restart  = cfg_write;

	assign adv2     = !s2_v_q || !qstat.full;
	assign ld1      = !s1_v_q || adv2;
	assign in_stall = !ld1;
	assign accept   = in_valid && ld1;
	assign push     = s2_v_q && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DEF_FRAME_WIDTH;
			frame_height_q <= DEF_FRAME_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		img_q <= {{CFG_W{1'b0}}, w_eff} * {{CFG_W{1'b0}}, h_eff};
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			luma_q       <= '0;
			chroma_idx_q <= '0;
		end else if (restart || (accept && fend)) begin
			column_q     <= '0;
			row_q        <= '0;
			luma_q       <= '0;
			chroma_idx_q <= '0;
		end else if (accept) begin
			luma_q <= luma_q + LUMA_W'(1);
			if (chroma)
				chroma_idx_q <= chroma_idx_q + CHROMA_W'(1);
			if (col_last) begin
				column_q <= '0;
				row_q    <= row_q + ROW_W'(1);
			end else begin
				column_q <= column_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (ld1)
				s1_v_q <= in_valid;
			if (adv2)
				s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1        <= red;
			green_s1      <= green;
			blue_s1       <= blue;
			column_s1     <= column_q;
			luma_s1       <= luma_q;
			chroma_idx_s1 <= chroma_idx_q;
			chroma_s1     <= chroma;
			fend_s1       <= fend;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && s1_v_q) begin
			red_s2    <= red_s1;
			blue_s2   <= blue_s1;
			t_yr_s2   <= mul_shr(red_s1, K_Y_R);
			t_yg_s2   <= mul_shr(green_s1, K_Y_G);
			t_yb_s2   <= mul_shr(blue_s1, K_Y_B);
			t_ur_s2   <= mul_shr(red_s1, K_U_R);
			t_ug_s2   <= mul_shr(green_s1, K_U_G);
			t_vg_s2   <= mul_shr(green_s1, K_V_G);
			t_vb_s2   <= mul_shr(blue_s1, K_V_B);
			luma_s2   <= luma_s1;
			u_addr_s2 <= img_q[ADDR_W-1:0] + ADDR_W'(chroma_idx_s1);
			v_addr_s2 <= img_q[ADDR_W-1:0] + ADDR_W'(img_q >> 2) + ADDR_W'(chroma_idx_s1);
			src_s2    <= img_q[SRC_W-1:0] - SRC_W'(w_eff) - luma_s1
			             + (SRC_W'(column_s1) << 1);
			chroma_s2 <= chroma_s1;
			fend_s2   <= fend_s1;
		end
	end

	always_comb begin
		y_sum = {2'b00, t_yr_s2} + {2'b00, t_yg_s2} + {2'b00, t_yb_s2};
		u_sum = {3'b000, blue_s2[COMP_W-1:1]} + CHROMA_OFFSET
		        - {2'b00, t_ur_s2} - {2'b00, t_ug_s2};
		v_sum = {3'b000, red_s2[COMP_W-1:1]} + CHROMA_OFFSET
		        - {2'b00, t_vg_s2} - {2'b00, t_vb_s2};
		push_item.y         = y_sum[SAMPLE_W-1:0];
		push_item.u         = u_sum[SAMPLE_W-1:0];
		push_item.v         = v_sum[SAMPLE_W-1:0];
		push_item.luma_addr = luma_s2;
		push_item.u_addr    = u_addr_s2;
		push_item.v_addr    = v_addr_s2;
		push_item.src       = src_s2;
		push_item.chroma    = chroma_s2;
		push_item.fend      = fend_s2;
	end

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_v_q) else $error("accepted word not held in first stage");

endmodule

FILE: rtl/ryuv_back.sv
// ----------------------------------------------------------------------------
// ryuv_back
// Result sequencer: emits Y, then U and V at chroma sites, into an output register.
// ----------------------------------------------------------------------------
module ryuv_back import ryuv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ryuv_item_t          head,
	input  ryuv_qstat_t         qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          plane,
	output logic [SAMPLE_W-1:0] sample_value,
	output logic [ADDR_W-1:0]   write_address,
	output logic [SRC_W-1:0]    source_index,
	output logic                last_of_pixel,
	output logic                frame_end
);

	plane_t              phase_q, phase_d;
	logic                out_valid_q;
	plane_t              plane_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SRC_W-1:0]    src_q;
	logic                last_q, fend_q;
	logic                take, last;
	logic [SAMPLE_W-1:0] sample_d;
	logic [ADDR_W-1:0]   addr_d;

	assign take = !qstat.empty && (!out_valid_q || !out_stall);
	assign last = !head.chroma || (phase_q == PLANE_V);
	assign pop  = take && last;

	always_comb begin
		phase_d  = PLANE_Y;
		sample_d = head.y;
		addr_d   = {{(ADDR_W-LUMA_W){1'b0}}, head.luma_addr};
		unique case (phase_q)
			PLANE_Y: begin
				phase_d = PLANE_U;
			end
			PLANE_U: begin
				phase_d  = PLANE_V;
				sample_d = head.u;
				addr_d   = head.u_addr;
			end
			PLANE_V: begin
				phase_d  = PLANE_Y;
				sample_d = head.v;
				addr_d   = head.v_addr;
			end
			default: phase_d = PLANE_Y;
		endcase
		if (last)
			phase_d = PLANE_Y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PLANE_Y;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				phase_q <= phase_d;
			if (take)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			plane_q  <= phase_q;
			sample_q <= sample_d;
			addr_q   <= addr_d;
			src_q    <= head.src;
			last_q   <= last;
			fend_q   <= head.fend;
		end
	end

	assign out_valid     = out_valid_q;
	assign plane         = plane_q;
	assign sample_value  = sample_q;
	assign write_address = addr_q;
	assign source_index  = src_q;
	assign last_of_pixel = last_q;
	assign frame_end     = fend_q;

	a_hold_mid_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PLANE_Y) |-> !qstat.empty) else $error("pixel word lost mid sequence");

	a_chroma_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PLANE_Y) |-> head.chroma) else $error("chroma phase on luma-only word");

endmodule

FILE: rtl/rgb_to_yuv420_planar.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_planar
// RGB pixel stream to planar YUV 4:2:0 samples with buffer addresses.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle while the internal queue has
// room; each yields a luma word, and a pixel at odd column and odd row also
// yields U and V words, all on one result port that moves one word per cycle
// while out_stall is low. That single result port sets the sustained rate;
// pixels keep entering while earlier words wait in the queue. A pixel's
// words pass the front stages s1 and s2, the queue and the output register.
// Writing frame_width or frame_height restarts the frame; sizes are clamped
// to [2, MAX] and rounded down to even.
module rgb_to_yuv420_planar import ryuv_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COMP_W-1:0]    red,
	input  logic [COMP_W-1:0]    green,
	input  logic [COMP_W-1:0]    blue,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           plane,
	output logic [SAMPLE_W-1:0]  sample_value,
	output logic [ADDR_W-1:0]    write_address,
	output logic [SRC_W-1:0]     source_index,
	output logic                 last_of_pixel,
	output logic                 frame_end
);

	logic        push, pop;
	ryuv_item_t  push_item, head;
	ryuv_qstat_t qstat;

	ryuv_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.push     (push),
		.push_item(push_item),
		.qstat    (qstat)
	);

	ryuv_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	ryuv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.plane        (plane),
		.sample_value (sample_value),
		.write_address(write_address),
		.source_index (source_index),
		.last_of_pixel(last_of_pixel),
		.frame_end    (frame_end)
	);

endmodule
